// ===== rtl/ffisa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffisa_pkg
// Shared constants and types for the first-fit interval slot allocator.
// ----------------------------------------------------------------------------
package ffisa_pkg;

  localparam int SLOTS         = 64;
  localparam int POSITION_BITS = 8;
  localparam int KIND_BITS     = 3;
  localparam int IDX_BITS      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_BITS      = $clog2(SLOTS + 1);
  localparam int INDEX_OUT_BITS = 6;
  localparam int COUNT_OUT_BITS = 7;

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  typedef logic [KIND_BITS-1:0]     kind_t;
  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [IDX_BITS-1:0]      idx_t;
  typedef logic [CNT_BITS-1:0]      cnt_t;

  typedef struct packed {
    kind_t kind;
    pos_t  first;
    pos_t  last;
  } slot_entry_t;

  localparam int ENTRY_BITS = $bits(slot_entry_t);

endpackage

// ===== rtl/ffisa_if.sv =====
// ----------------------------------------------------------------------------
// ffisa request and result channels
// Valid/ready channels carrying one request beat and one result beat.
// ----------------------------------------------------------------------------
interface ffisa_req_if;
  import ffisa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [KIND_BITS-1:0]     kind;
  logic                     optimizable;
  logic [POSITION_BITS-1:0] first_use;
  logic [POSITION_BITS-1:0] last_use;

  modport source (output valid, opcode, kind, optimizable, first_use, last_use,
                  input ready);
  modport sink   (input valid, opcode, kind, optimizable, first_use, last_use,
                  output ready);
endinterface

interface ffisa_rsp_if;
  import ffisa_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [INDEX_OUT_BITS-1:0] slot_index;
  logic                      reused;
  logic                      overflow;
  logic [COUNT_OUT_BITS-1:0] slots_in_use;

  modport source (output valid, slot_index, reused, overflow, slots_in_use,
                  input ready);
  modport sink   (input valid, slot_index, reused, overflow, slots_in_use,
                  output ready);
endinterface

// ===== rtl/ffisa_ram.sv =====
// ----------------------------------------------------------------------------
// ffisa_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffisa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/first_fit_interval_slot_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_interval_slot_allocator_top
// First-fit allocator of lifetime intervals to storage slots.
// ----------------------------------------------------------------------------
// One request is handled at a time. The table has a single read port, so a
// first-fit scan reads one entry per cycle. Results are registered after
// accept as follows:
//   clear: through EMIT.
//   allocation that opens a new slot directly: through NEW, then EMIT.
//   allocation that scans: through SCAN until the first fitting slot, or
//   through SCAN over all occupied slots and then NEW, then EMIT.
// The next request is accepted in the cycle after the result is registered,
// even while that result waits downstream. A new result is not registered
// while the previous beat is still waiting. The table needs no clearing
// after reset.
// ----------------------------------------------------------------------------
module first_fit_interval_slot_allocator_top (
  input  logic        clk,
  input  logic        rst,
  ffisa_req_if.sink   req,
  ffisa_rsp_if.source rsp
);
  import ffisa_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_NEW  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]  state, state_next;
  cnt_t        count, count_next;
  idx_t        chk, chk_next;
  kind_t       kind;
  pos_t        lo, hi;

  logic        res_valid, res_valid_next;
  idx_t        res_index, res_index_next;
  logic        res_reused, res_reused_next;
  logic        res_overflow, res_overflow_next;

  logic        load;
  idx_t        out_index;
  logic        out_reused;
  logic        out_overflow;
  cnt_t        out_count;

  logic        we;
  idx_t        waddr, raddr;
  slot_entry_t wdata, rdata;

  logic        accept, overlap, match, more;
  pos_t        in_lo, in_hi;

  ffisa_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign accept  = req.valid && req.ready;
  assign in_lo   = (req.last_use < req.first_use) ? req.last_use : req.first_use;
  assign in_hi   = (req.last_use < req.first_use) ? req.first_use : req.last_use;
  assign overlap = (rdata.first <= hi) && (lo <= rdata.last);
  assign match   = !overlap && (rdata.kind == kind);
  assign more    = (cnt_t'(chk) + cnt_t'(1)) < count;

  assign req.ready = (state == ST_IDLE);

  always_comb begin
    state_next        = state;
    count_next        = count;
    chk_next          = chk;
    res_valid_next    = res_valid && !rsp.ready;
    res_index_next    = res_index;
    res_reused_next   = res_reused;
    res_overflow_next = res_overflow;
    load              = 1'b0;
    we                = 1'b0;
    waddr             = chk;
    wdata             = rdata;
    raddr             = '0;
    unique case (state)
      ST_IDLE: begin
        chk_next = '0;
        if (accept) begin
          if (req.opcode == OP_CLEAR) begin
            count_next        = '0;
            res_index_next    = '0;
            res_reused_next   = 1'b0;
            res_overflow_next = 1'b0;
            state_next        = ST_EMIT;
          end else if (count == '0 || !req.optimizable) begin
            state_next = ST_NEW;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        raddr = chk + idx_t'(1);
        if (match) begin
          we                = 1'b1;
          waddr             = chk;
          wdata.kind        = rdata.kind;
          wdata.first       = (lo < rdata.first) ? lo : rdata.first;
          wdata.last        = (hi > rdata.last) ? hi : rdata.last;
          res_index_next    = chk;
          res_reused_next   = 1'b1;
          res_overflow_next = 1'b0;
          state_next        = ST_EMIT;
        end else if (more) begin
          chk_next = chk + idx_t'(1);
        end else begin
          state_next = ST_NEW;
        end
      end
      ST_NEW: begin
        res_reused_next = 1'b0;
        if (count == cnt_t'(SLOTS)) begin
          res_index_next    = '0;
          res_overflow_next = 1'b1;
        end else begin
          we                = 1'b1;
          waddr             = count[IDX_BITS-1:0];
          wdata.kind        = kind;
          wdata.first       = lo;
          wdata.last        = hi;
          res_index_next    = count[IDX_BITS-1:0];
          res_overflow_next = 1'b0;
          count_next        = count + cnt_t'(1);
        end
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!res_valid || rsp.ready) begin
          load           = 1'b1;
          res_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      res_valid <= res_valid_next;
    end
    chk          <= chk_next;
    res_index    <= res_index_next;
    res_reused   <= res_reused_next;
    res_overflow <= res_overflow_next;
    if (load) begin
      out_index    <= res_index;
      out_reused   <= res_reused;
      out_overflow <= res_overflow;
      out_count    <= count;
    end
    if (accept) begin
      kind <= req.kind;
      lo   <= in_lo;
      hi   <= in_hi;
    end
  end

  // Hold result fields steady in the output register while the beat waits.
  assign rsp.valid        = res_valid;
  assign rsp.slot_index   = INDEX_OUT_BITS'(out_index);
  assign rsp.reused       = out_reused;
  assign rsp.overflow     = out_overflow;
  assign rsp.slots_in_use = COUNT_OUT_BITS'(out_count);

  assert property (@(posedge clk) disable iff (rst) count <= cnt_t'(SLOTS))
    else $error("slot count beyond table size");

  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.overflow |-> out_count == cnt_t'(SLOTS) && !rsp.reused)
    else $error("overflow reported with free slots");

  assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> cnt_t'(chk) < count)
    else $error("scan beyond occupied slots");

  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.reused |-> cnt_t'(out_index) < out_count)
    else $error("reuse of unoccupied slot");

endmodule

// ===== tb/tb_first_fit_interval_slot_allocator_top.sv =====
// ----------------------------------------------------------------------------
// tb_first_fit_interval_slot_allocator_top
// Self-checking bench for the first-fit interval slot allocator. A local
// slot table predicts the grant for every request beat. Grants are checked
// in order against the returned beats. The stimulus covers directed corner
// requests, a full table with overflow, output back-pressure, and random
// clear/allocate sequences, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_first_fit_interval_slot_allocator_top;
  import ffisa_pkg::*;

  localparam int ITEMS        = 1400;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int MAX_POS      = (1 << POSITION_BITS) - 1;

  typedef struct {
    logic  opcode;
    kind_t kind;
    logic  optimizable;
    pos_t  first_use;
    pos_t  last_use;
  } request_t;

  typedef struct {
    logic [INDEX_OUT_BITS-1:0] slot_index;
    logic                      reused;
    logic                      overflow;
    logic [COUNT_OUT_BITS-1:0] slots_in_use;
  } grant_t;

  logic clk;
  logic rst;

  ffisa_req_if req_if ();
  ffisa_rsp_if rsp_if ();

  first_fit_interval_slot_allocator_top uut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  kind_t  tbl_kind  [SLOTS];
  pos_t   tbl_first [SLOTS];
  pos_t   tbl_last  [SLOTS];
  int     tbl_count;

  grant_t expected_grants [$];
  int     sent_count;
  int     mismatches;
  int     cycle_count;
  int     hold_off;
  bit     calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic grant_t allocate_slot(input request_t r);
    grant_t g;
    pos_t   lo;
    pos_t   hi;
    g = '{default: '0};
    if (r.opcode == OP_CLEAR) begin
      tbl_count = 0;
      return g;
    end
    lo = r.first_use;
    hi = r.last_use;
    if (hi < lo) begin
      lo = r.last_use;
      hi = r.first_use;
    end
    if (tbl_count > 0 && r.optimizable) begin
      for (int i = 0; i < tbl_count; i++) begin
        if (!(tbl_first[i] <= hi && lo <= tbl_last[i]) && tbl_kind[i] == r.kind) begin
          if (lo < tbl_first[i]) tbl_first[i] = lo;
          if (hi > tbl_last[i]) tbl_last[i] = hi;
          g.slot_index   = INDEX_OUT_BITS'(i);
          g.reused       = 1'b1;
          g.slots_in_use = COUNT_OUT_BITS'(tbl_count);
          return g;
        end
      end
    end
    if (tbl_count >= SLOTS) begin
      g.overflow     = 1'b1;
      g.slots_in_use = COUNT_OUT_BITS'(SLOTS);
      return g;
    end
    tbl_kind[tbl_count]  = r.kind;
    tbl_first[tbl_count] = lo;
    tbl_last[tbl_count]  = hi;
    g.slot_index         = INDEX_OUT_BITS'(tbl_count);
    tbl_count            = tbl_count + 1;
    g.slots_in_use       = COUNT_OUT_BITS'(tbl_count);
    return g;
  endfunction

  function automatic request_t make_request(input logic op, input kind_t k, input logic opt,
                                            input pos_t f, input pos_t l);
    request_t r;
    r.opcode      = op;
    r.kind        = k;
    r.optimizable = opt;
    r.first_use   = f;
    r.last_use    = l;
    return r;
  endfunction

  function automatic request_t rand_alloc(input kind_t k, input int span, input int share_pct);
    int   lo;
    int   hi;
    logic opt;
    lo  = $urandom_range(0, MAX_POS);
    hi  = lo + $urandom_range(0, span);
    opt = ($urandom_range(0, 99) < share_pct);
    if (hi > MAX_POS) hi = MAX_POS;
    if ($urandom_range(0, 7) == 0) return make_request(OP_ALLOC, k, opt, pos_t'(hi), pos_t'(lo));
    return make_request(OP_ALLOC, k, opt, pos_t'(lo), pos_t'(hi));
  endfunction

  task automatic send_request(input request_t r);
    int     gap;
    grant_t g;
    g = allocate_slot(r);
    expected_grants = {expected_grants, g};
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.opcode      <= r.opcode;
    req_if.kind        <= r.kind;
    req_if.optimizable <= r.optimizable;
    req_if.first_use   <= r.first_use;
    req_if.last_use    <= r.last_use;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic wait_drain();
    req_if.valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver: random stalls, plus a counted hold-off when requested
  initial begin
    int stall;
    stall = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        rsp_if.ready <= 1'b0;
      end else if (hold_off > 0) begin
        rsp_if.ready <= 1'b0;
        hold_off--;
      end else if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        stall--;
      end else begin
        rsp_if.ready <= 1'b1;
        if (!calm) stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    grant_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: slot_index %0d reused %0d overflow %0d in_use %0d",
                   rsp_if.slot_index, rsp_if.reused, rsp_if.overflow, rsp_if.slots_in_use);
      end else begin
        want = expected_grants.pop_front();
        if (rsp_if.slot_index !== want.slot_index || rsp_if.reused !== want.reused ||
            rsp_if.overflow !== want.overflow || rsp_if.slots_in_use !== want.slots_in_use) begin
          mismatches++;
          if (mismatches <= 10)
            $display("grant mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     want.slot_index, want.reused, want.overflow, want.slots_in_use,
                     rsp_if.slot_index, rsp_if.reused, rsp_if.overflow, rsp_if.slots_in_use);
        end
      end
    end
  end

  task automatic test_directed();
    send_request(make_request(OP_CLEAR, 3'd7, 1'b1, 8'd255, 8'd255));
    send_request(make_request(OP_ALLOC, 3'd0, 1'b0, 8'd0, 8'd0));
    send_request(make_request(OP_ALLOC, 3'd7, 1'b1, 8'd255, 8'd255));
    send_request(make_request(OP_ALLOC, 3'd7, 1'b1, 8'd0, 8'd254));
    send_request(make_request(OP_ALLOC, 3'd0, 1'b1, 8'd200, 8'd10));
    send_request(make_request(OP_ALLOC, 3'd0, 1'b1, 8'd200, 8'd210));
    send_request(make_request(OP_ALLOC, 3'd0, 1'b1, 8'd201, 8'd255));
    send_request(make_request(OP_ALLOC, 3'd3, 1'b1, 8'd10, 8'd20));
    send_request(make_request(OP_ALLOC, 3'd3, 1'b0, 8'd30, 8'd40));
    send_request(make_request(OP_ALLOC, 3'd3, 1'b1, 8'd21, 8'd29));
    send_request(make_request(OP_ALLOC, 3'd3, 1'b1, 8'd29, 8'd29));
    send_request(make_request(OP_ALLOC, 3'd5, 1'b1, 8'd128, 8'd128));
    send_request(make_request(OP_ALLOC, 3'd1, 1'b1, 8'd85, 8'd170));
    send_request(make_request(OP_ALLOC, 3'd2, 1'b0, 8'd170, 8'd85));
    send_request(make_request(OP_ALLOC, 3'd4, 1'b1, 8'd15, 8'd240));
    send_request(make_request(OP_ALLOC, 3'd6, 1'b1, 8'd240, 8'd15));
    send_request(make_request(OP_CLEAR, 3'd0, 1'b0, 8'd0, 8'd0));
    send_request(make_request(OP_ALLOC, 3'd5, 1'b1, 8'd128, 8'd128));
    send_request(make_request(OP_ALLOC, 3'd5, 1'b1, 8'd127, 8'd127));
    send_request(make_request(OP_CLEAR, 3'd2, 1'b1, 8'd170, 8'd85));
  endtask

  task automatic test_full_table();
    for (int i = 0; i < SLOTS; i++)
      send_request(rand_alloc(kind_t'($urandom), 3, 0));
    send_request(rand_alloc(kind_t'($urandom), 3, 0));
    repeat (8) send_request(rand_alloc(kind_t'($urandom), 3, 100));
    send_request(make_request(OP_CLEAR, kind_t'($urandom), 1'b1, 8'd0, 8'd255));
    for (int i = 0; i < SLOTS + 2; i++)
      send_request(make_request(OP_ALLOC, 3'd6, 1'b1, 8'd0, 8'd255));
    send_request(make_request(OP_ALLOC, 3'd6, 1'b1, 8'd0, 8'd0));
    send_request(make_request(OP_CLEAR, kind_t'($urandom), 1'b0, 8'd255, 8'd0));
  endtask

  task automatic test_backpressure();
    wait_drain();
    calm     = 1'b1;
    hold_off = 300;
    repeat (12) send_request(rand_alloc(kind_t'($urandom_range(0, 1)), 20, 80));
    wait_drain();
    calm = 1'b0;
  endtask

  task automatic run_sequence();
    int    len;
    int    kinds;
    int    span;
    int    share_pct;
    kind_t base;
    len       = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 90) : $urandom_range(1, 30);
    kinds     = $urandom_range(1, 8);
    base      = kind_t'($urandom);
    share_pct = ($urandom_range(0, 3) == 0) ? 50 : 90;
    case ($urandom_range(0, 2))
      0: span = 0;
      1: span = 15;
      default: span = MAX_POS;
    endcase
    send_request(make_request(OP_CLEAR, kind_t'($urandom), 1'($urandom_range(0, 1)),
                              pos_t'($urandom), pos_t'($urandom)));
    repeat (len)
      send_request(rand_alloc(base + kind_t'($urandom_range(0, kinds - 1)), span, share_pct));
  endtask

  task automatic run_noise();
    repeat ($urandom_range(5, 30))
      send_request(make_request(($urandom_range(0, 3) == 0) ? OP_CLEAR : OP_ALLOC,
                                kind_t'($urandom), 1'($urandom_range(0, 1)),
                                pos_t'($urandom), pos_t'($urandom)));
  endtask

  task automatic test_random_sequences();
    while (sent_count < ITEMS) begin
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) run_noise();
      else run_sequence();
      if ($urandom_range(0, 11) == 0) wait_drain();
    end
    calm = 1'b0;
  endtask

  initial begin
    tbl_count          = 0;
    sent_count         = 0;
    mismatches         = 0;
    cycle_count        = 0;
    hold_off           = 0;
    calm               = 1'b0;
    rst                <= 1'b1;
    req_if.valid       <= 1'b0;
    req_if.opcode      <= OP_CLEAR;
    req_if.kind        <= '0;
    req_if.optimizable <= 1'b0;
    req_if.first_use   <= '0;
    req_if.last_use    <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_backpressure();
    test_random_sequences();
    wait_drain();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
